// ----- src/euler_path_finder_defines.svh -----
// Assertion macros for the Euler path finder checker.
`ifndef EULER_PATH_FINDER_DEFINES_SVH
`define EULER_PATH_FINDER_DEFINES_SVH
// Assert a property on the rising clock, disabled while in reset.
`define EPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert a property on the rising clock, during reset too.
`define EPF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- src/epf_pkg.sv -----
//------------------------------------------------------------------------------
// epf_pkg
// Types, status codes and controller states of the Euler path finder.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package epf_pkg;
  localparam int unsigned EPF_MAX_VERTICES = 32;
  localparam int unsigned EPF_MAX_EDGES    = 32;
  localparam int unsigned VW = 5;

  typedef enum logic [2:0] {
    ST_FOUND = 3'd0, ST_ODD = 3'd1, ST_DISC = 3'd2, ST_NOEDGE = 3'd3, ST_OVFL = 3'd4
  } epf_status_t;

  typedef enum logic {OP_ADD = 1'b0, OP_RUN = 1'b1} epf_op_t;

  typedef struct packed {
    logic           operation;
    logic [VW-1:0]  first_vertex;
    logic [VW-1:0]  second_vertex;
  } epf_in_t;

  typedef struct packed {
    logic [VW-1:0]  path_vertex;
    logic [2:0]     status;
    logic           closed_circuit;
    logic           last;
  } epf_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_ODD_SCAN, S_CHECK, S_INIT, S_TOP, S_CURSOR,
    S_EDGE_RD, S_EDGE_EVAL, S_USED_CHECK, S_EMIT_PREP, S_EMIT, S_FAIL
  } epf_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic add_edge;
    logic scan_clr;
    logic scan_odd;
    logic walk_init;
    logic read_top;
    logic read_cursor;
    logic read_edge;
    logic eval_edge;
    logic emit_prep;
    logic emit;
    logic fail;
  } epf_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic overflow;
    logic odd_bad;
    logic no_edges;
    logic stack_empty;
    logic edge_skip;
    logic unused_found;
    logic emit_last;
  } epf_stat_t;
endpackage

// ----- src/epf_ctrl.sv -----
//------------------------------------------------------------------------------
// epf_ctrl
// Controller state machine: sequences loads, scans, the walk and emission.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module epf_ctrl
  import epf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      op_run,
  input  epf_stat_t stat,
  output epf_cmd_t  cmd,
  output logic      busy
);
  epf_state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:       if (start) state_nxt = op_run ? S_ODD_SCAN : S_ADD;
      S_ADD:        state_nxt = S_IDLE;
      S_ODD_SCAN:   if (stat.scan_done) state_nxt = S_CHECK;
      S_CHECK: begin
        if (stat.overflow || stat.odd_bad || stat.no_edges) state_nxt = S_FAIL;
        else state_nxt = S_INIT;
      end
      S_INIT:       state_nxt = S_TOP;
      S_TOP:        state_nxt = stat.stack_empty ? S_USED_CHECK : S_CURSOR;
      S_CURSOR:     state_nxt = S_EDGE_RD;
      S_EDGE_RD:    state_nxt = S_EDGE_EVAL;
      S_EDGE_EVAL:  state_nxt = stat.edge_skip ? S_EDGE_RD : S_TOP;
      S_USED_CHECK: state_nxt = stat.unused_found ? S_FAIL : S_EMIT_PREP;
      S_EMIT_PREP:  state_nxt = S_EMIT;
      S_EMIT:       if (stat.emit_last) state_nxt = S_IDLE;
      S_FAIL:       state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:       cmd.scan_clr = start;
      S_ADD:        cmd.add_edge = 1'b1;
      S_ODD_SCAN:   cmd.scan_odd = 1'b1;
      S_CHECK:      cmd = '0;
      S_INIT:       cmd.walk_init = 1'b1;
      S_TOP:        cmd.read_top = !stat.stack_empty;
      S_CURSOR:     cmd.read_cursor = 1'b1;
      S_EDGE_RD:    cmd.read_edge = 1'b1;
      S_EDGE_EVAL:  cmd.eval_edge = 1'b1;
      S_USED_CHECK: cmd = '0;
      S_EMIT_PREP:  cmd.emit_prep = 1'b1;
      S_EMIT:       cmd.emit = 1'b1;
      S_FAIL:       cmd.fail = 1'b1;
      default:      cmd = '0;
    endcase
  end

  assign busy = (state_r != S_IDLE);
endmodule

// ----- src/epf_dp.sv -----
//------------------------------------------------------------------------------
// epf_dp
// Datapath: edge store, degree and cursor tables, walk stack, circuit store.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module epf_dp
  import epf_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = EPF_MAX_VERTICES,
  parameter int unsigned MAX_EDGES    = EPF_MAX_EDGES
)(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  epf_in_t   in_item,
  input  epf_cmd_t  cmd,
  output epf_stat_t stat,
  output logic      out_valid,
  output epf_out_t  out_item
);
  localparam int unsigned EW = $clog2(MAX_EDGES + 1);     // count of edges
  localparam int unsigned EI = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned VI = $clog2(MAX_VERTICES);
  localparam int unsigned SD = MAX_EDGES + 1;
  localparam int unsigned SW = $clog2(SD + 1);
  localparam int unsigned SI = $clog2(SD);
  localparam int unsigned DW = 6;

  // Memories
  logic [VW-1:0] edge_a_mem [MAX_EDGES];
  logic [VW-1:0] edge_b_mem [MAX_EDGES];
  logic [VW-1:0] stack_mem  [SD];
  logic [VW-1:0] circ_mem   [SD];

  // Per-vertex and per-edge register tables
  logic [DW-1:0] deg_r      [MAX_VERTICES];
  logic [EW-1:0] cur_r      [MAX_VERTICES];
  logic          used_r     [MAX_EDGES];

  epf_in_t        in_r;
  logic           in_ok, add_ok, add_ovf;
  logic [EW-1:0]  edge_count_r;
  logic           overflow_r;
  logic [VI-1:0]  scan_r;
  logic [1:0]     odd_cnt_r;
  logic [VW-1:0]  odd_v_r, nz_v_r, start_v;
  logic           have_odd_r, have_nz_r;
  logic           closed_r;
  logic [SW-1:0]  stack_depth_r, circ_count_r, emit_idx_r;
  logic [SW-1:0]  sd_m1, rd_off, circ_rd_idx;
  logic [VW-1:0]  top_v_r, ea_r, eb_r, far_v, circ_rd_r;
  logic [EW-1:0]  e_r;
  logic [EI-1:0]  e_idx;
  logic [VI-1:0]  top_idx;
  logic           e_live, e_incident, e_skip, e_hit, e_retire;
  logic           unused_any;

  assign in_ok = (in_r.first_vertex != in_r.second_vertex) &&
                 (32'(in_r.first_vertex) < MAX_VERTICES) &&
                 (32'(in_r.second_vertex) < MAX_VERTICES);
  assign add_ok  = cmd.add_edge && in_ok && (edge_count_r < EW'(MAX_EDGES));
  assign add_ovf = cmd.add_edge && in_ok && (edge_count_r >= EW'(MAX_EDGES));

  // Capture item
  always_ff @(posedge clk) begin
    if (start) in_r <= in_item;
  end

  // Edge store writes and registered edge reads
  always_ff @(posedge clk) begin
    if (add_ok) begin
      edge_a_mem[EI'(edge_count_r)] <= in_r.first_vertex;
      edge_b_mem[EI'(edge_count_r)] <= in_r.second_vertex;
    end
    if (cmd.read_edge) begin
      ea_r <= edge_a_mem[e_idx];
      eb_r <= edge_b_mem[e_idx];
    end
  end

  // Degree table: bump both ends of an added edge, drop all on a failed run
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.fail) begin
      for (int i = 0; i < int'(MAX_VERTICES); i++) deg_r[i] <= '0;
    end else if (add_ok) begin
      deg_r[VI'(in_r.first_vertex)]  <= deg_r[VI'(in_r.first_vertex)] + 1'b1;
      deg_r[VI'(in_r.second_vertex)] <= deg_r[VI'(in_r.second_vertex)] + 1'b1;
    end
  end

  // Degree scan: count odd vertices (saturating) and note start candidates
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.scan_clr) begin
      scan_r     <= '0;
      odd_cnt_r  <= '0;
      have_odd_r <= 1'b0;
      have_nz_r  <= 1'b0;
    end else if (cmd.scan_odd) begin
      scan_r <= scan_r + 1'b1;
      if (deg_r[scan_r][0]) begin
        if (!have_odd_r) begin
          odd_v_r    <= VW'(scan_r);
          have_odd_r <= 1'b1;
        end
        if (odd_cnt_r != 2'd3) odd_cnt_r <= odd_cnt_r + 1'b1;
      end
      if (deg_r[scan_r] != '0 && !have_nz_r) begin
        nz_v_r    <= VW'(scan_r);
        have_nz_r <= 1'b1;
      end
    end
  end
  assign start_v = have_odd_r ? odd_v_r : nz_v_r;

  // Edge test at the cursor of the top vertex
  assign e_idx      = (e_r < EW'(MAX_EDGES)) ? EI'(e_r) : '0;
  assign top_idx    = VI'(top_v_r);
  assign e_live     = (e_r < edge_count_r);
  assign e_incident = (ea_r == top_v_r) || (eb_r == top_v_r);
  assign e_skip     = e_live && (used_r[e_idx] || !e_incident);
  assign e_hit      = cmd.eval_edge && e_live && !e_skip && (stack_depth_r < SW'(SD));
  assign e_retire   = cmd.eval_edge && !e_skip && !e_hit;
  assign far_v      = (ea_r == top_v_r) ? eb_r : ea_r;

  // Cursor table and edge index
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.fail || cmd.walk_init) begin
      for (int i = 0; i < int'(MAX_VERTICES); i++) cur_r[i] <= '0;
    end else if (e_hit) begin
      cur_r[top_idx] <= e_r + 1'b1;
    end else if (e_retire) begin
      cur_r[top_idx] <= e_r;
    end
    if (cmd.read_cursor) e_r <= cur_r[top_idx];
    else if (cmd.eval_edge && e_skip) e_r <= e_r + 1'b1;
  end

  // Used flags
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.fail || cmd.walk_init) begin
      for (int i = 0; i < int'(MAX_EDGES); i++) used_r[i] <= 1'b0;
    end else if (e_hit) begin
      used_r[e_idx] <= 1'b1;
    end
  end

  // Flag any stored edge that the walk left unused
  always_comb begin
    unused_any = 1'b0;
    for (int i = 0; i < int'(MAX_EDGES); i++) begin
      if (EW'(i) < edge_count_r && !used_r[i]) unused_any = 1'b1;
    end
  end

  // Walk stack: push the far end on a hit, read the top registered
  assign sd_m1 = stack_depth_r - 1'b1;
  always_ff @(posedge clk) begin
    if (cmd.walk_init) stack_mem[0] <= start_v;
    else if (e_hit) stack_mem[SI'(stack_depth_r)] <= far_v;
    if (cmd.read_top) top_v_r <= stack_mem[SI'(sd_m1)];
  end

  // Circuit store: append retired vertices, read back in reverse
  assign rd_off      = cmd.emit ? SW'(emit_idx_r + 1'b1) : '0;
  assign circ_rd_idx = circ_count_r - 1'b1 - rd_off;
  always_ff @(posedge clk) begin
    if (e_retire && circ_count_r < SW'(SD)) circ_mem[SI'(circ_count_r)] <= top_v_r;
    if (cmd.emit_prep || (cmd.emit && !stat.emit_last))
      circ_rd_r <= circ_mem[SI'(circ_rd_idx)];
  end

  // Edge count and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.fail) begin
      edge_count_r <= '0;
      overflow_r   <= 1'b0;
    end else if (add_ok) begin
      edge_count_r <= edge_count_r + 1'b1;
    end else if (add_ovf) begin
      overflow_r <= 1'b1;
    end
  end

  // Stack depth, circuit length and emit index
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.fail) begin
      stack_depth_r <= '0;
      circ_count_r  <= '0;
      emit_idx_r    <= '0;
    end else if (cmd.walk_init) begin
      stack_depth_r <= SW'(1);
      circ_count_r  <= '0;
      emit_idx_r    <= '0;
    end else begin
      if (e_hit) begin
        stack_depth_r <= stack_depth_r + 1'b1;
      end else if (e_retire) begin
        stack_depth_r <= sd_m1;
        if (circ_count_r < SW'(SD)) circ_count_r <= circ_count_r + 1'b1;
      end
      if (cmd.emit) emit_idx_r <= emit_idx_r + 1'b1;
    end
  end

  // Closed circuit when no vertex has odd degree
  always_ff @(posedge clk) begin
    if (!rst_n) closed_r <= 1'b0;
    else if (cmd.walk_init) closed_r <= (odd_cnt_r == 2'd0);
  end

  // Status to the controller
  always_comb begin
    stat = '0;
    stat.scan_done    = (scan_r == VI'(MAX_VERTICES - 1));
    stat.overflow     = overflow_r;
    stat.odd_bad      = (odd_cnt_r == 2'd1) || (odd_cnt_r == 2'd3);
    stat.no_edges     = (edge_count_r == '0);
    stat.stack_empty  = (stack_depth_r == '0);
    stat.edge_skip    = e_skip;
    stat.unused_found = unused_any;
    stat.emit_last    = (emit_idx_r + 1'b1 == circ_count_r);
  end

  // Result item: path vertex or one status item
  always_comb begin
    out_valid = cmd.emit || cmd.fail;
    out_item  = '0;
    if (cmd.emit) begin
      out_item.path_vertex    = circ_rd_r;
      out_item.status         = ST_FOUND;
      out_item.closed_circuit = closed_r;
      out_item.last           = stat.emit_last;
    end else if (cmd.fail) begin
      out_item.last = 1'b1;
      priority if (overflow_r) out_item.status = ST_OVFL;
      else if (stat.odd_bad) out_item.status = ST_ODD;
      else if (edge_count_r == '0) out_item.status = ST_NOEDGE;
      else out_item.status = ST_DISC;
    end
  end
endmodule

// ----- src/euler_path_finder.sv -----
//------------------------------------------------------------------------------
// euler_path_finder
// Hierholzer Euler path search over a loaded undirected edge list.
//------------------------------------------------------------------------------
// channel | ports                       | handshake
// input   | start, busy, in_item        | taken when start && !busy
// result  | out_valid, out_item         | one cycle strobe, no backpressure
// An add item is accepted in S_IDLE and written to the store in S_ADD.
// A run scans MAX_VERTICES degrees, then checks them in S_CHECK; a failing
// check gives its status item the next cycle and clears the store then.
// The walk runs S_INIT, then S_TOP and S_CURSOR per stack visit and S_EDGE_RD
// and S_EDGE_EVAL per edge probed, one unused-edge check, one prefetch step and
// one vertex per cycle. Reset is synchronous; the receiver cannot stall results.
`timescale 1ns / 1ps
module euler_path_finder
  import epf_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = EPF_MAX_VERTICES,
  parameter int unsigned MAX_EDGES    = EPF_MAX_EDGES
)(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  epf_in_t  in_item,
  output logic     busy,
  output logic     out_valid,
  output epf_out_t out_item
);
  epf_cmd_t  cmd;
  epf_stat_t stat;

  epf_ctrl u_ctrl (
    .clk, .rst_n, .start, .op_run(in_item.operation == OP_RUN),
    .stat, .cmd, .busy
  );

  epf_dp #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk, .rst_n, .start(start && !busy), .in_item, .cmd, .stat,
    .out_valid, .out_item
  );
endmodule

// ----- src/epf_checker.sv -----
//------------------------------------------------------------------------------
// epf_checker
// Port-level checks of the Euler path finder.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "euler_path_finder_defines.svh"
module epf_checker
  import epf_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input epf_out_t out_item
);
  `EPF_ASSERT(a_out_busy, out_valid |-> busy, "result outside a run")
  `EPF_ASSERT(a_fail_last, out_valid && out_item.status != ST_FOUND |-> out_item.last, "status result not last")
  `EPF_ASSERT(a_last_free, out_valid && out_item.last |=> !out_valid, "result after last")
  `EPF_ASSERT(a_take_busy, start && !busy |=> busy, "accepted item left block idle")
  `EPF_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !busy && !out_valid, "busy after reset")
endmodule

bind euler_path_finder epf_checker u_epf_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_item
);

// ----- tb/testbench.sv -----
//------------------------------------------------------------------------------
// testbench
// Drives edge loads and run items into the Euler path finder and checks each
// emitted path vertex or status against an in-bench Hierholzer predictor.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

class path_scoreboard;
  logic [4:0] end_a[32];
  logic [4:0] end_b[32];
  logic [5:0] degree[32];
  int unsigned edge_total;
  bit overflow_flag;
  epf_pkg::epf_out_t pending_results[$];
  int unsigned fail_count;
  int unsigned found_runs;
  int unsigned status_runs;

  function void clear_graph();
    foreach (degree[i]) degree[i] = '0;
    edge_total = 0;
    overflow_flag = 0;
  endfunction

  function void push_status(epf_pkg::epf_status_t code);
    epf_pkg::epf_out_t r;
    r.path_vertex = '0;
    r.status = code;
    r.closed_circuit = 1'b0;
    r.last = 1'b1;
    pending_results = {pending_results, r};
    status_runs++;
    clear_graph();
  endfunction

  // Predict the results of one accepted item.
  function void note_item(epf_pkg::epf_in_t it);
    bit used[32];
    logic [5:0] cursor[32];
    logic [4:0] stack_a[33];
    logic [4:0] circuit_a[33];
    int unsigned depth, circ_total;
    int unsigned odd_total, e;
    logic [4:0] v, origin;
    bit have_origin;
    epf_pkg::epf_out_t r;
    odd_total = 0;
    have_origin = 0;
    origin = '0;
    depth = 0;
    circ_total = 0;
    if (it.operation == epf_pkg::OP_ADD) begin
      if (it.first_vertex == it.second_vertex) return;
      if (edge_total >= 32) begin
        overflow_flag = 1;
        return;
      end
      end_a[edge_total] = it.first_vertex;
      end_b[edge_total] = it.second_vertex;
      degree[it.first_vertex] = degree[it.first_vertex] + 6'd1;
      degree[it.second_vertex] = degree[it.second_vertex] + 6'd1;
      edge_total++;
      return;
    end
    if (overflow_flag) begin
      push_status(epf_pkg::ST_OVFL);
      return;
    end
    for (int i = 0; i < 32; i++) begin
      if (degree[i][0]) begin
        if (!have_origin) begin
          origin = 5'(i);
          have_origin = 1;
        end
        odd_total++;
      end
    end
    if (odd_total != 0 && odd_total != 2) begin
      push_status(epf_pkg::ST_ODD);
      return;
    end
    if (edge_total == 0) begin
      push_status(epf_pkg::ST_NOEDGE);
      return;
    end
    if (!have_origin) begin
      for (int i = 31; i >= 0; i--) if (degree[i] != 0) origin = 5'(i);
    end
    foreach (used[i]) used[i] = 0;
    foreach (cursor[i]) cursor[i] = '0;
    stack_a[0] = origin;
    depth = 1;
    // Walk: take the lowest unused edge from the top vertex, else retire it.
    while (depth > 0) begin
      v = stack_a[depth - 1];
      e = cursor[v];
      while (e < edge_total && (used[e] || (end_a[e] != v && end_b[e] != v))) e++;
      if (e < edge_total && depth < 33) begin
        used[e] = 1;
        cursor[v] = 6'(e + 1);
        stack_a[depth] = (end_a[e] == v) ? end_b[e] : end_a[e];
        depth++;
      end else begin
        cursor[v] = 6'(e);
        if (circ_total < 33) begin
          circuit_a[circ_total] = v;
          circ_total++;
        end
        depth--;
      end
    end
    for (int i = 0; i < edge_total; i++) begin
      if (!used[i]) begin
        push_status(epf_pkg::ST_DISC);
        return;
      end
    end
    for (int k = int'(circ_total) - 1; k >= 0; k--) begin
      r.path_vertex = circuit_a[k];
      r.status = epf_pkg::ST_FOUND;
      r.closed_circuit = (odd_total == 0);
      r.last = (k == 0);
      pending_results = {pending_results, r};
    end
    found_runs++;
  endfunction

  function void check_result(epf_pkg::epf_out_t got);
    epf_pkg::epf_out_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %p", $time, got);
      fail_count++;
      return;
    end
    want = pending_results.pop_front();
    if (got !== want) begin
      $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
      fail_count++;
    end
  endfunction
endclass

module testbench;
  import epf_pkg::*;

  localparam int IN_W = $bits(epf_in_t);

  logic clk;
  logic rst_n;
  logic start;
  epf_in_t in_item;
  logic busy;
  logic out_valid;
  epf_out_t out_item;

  path_scoreboard board;
  int unsigned idle_cycles;
  int unsigned items_sent;
  bit quiet_stretch;
  bit all_sent;

  euler_path_finder dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item),
    .busy(busy), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Check results and track acceptance for the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) board.check_result(out_item);
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("FAIL euler_path_finder");
        $finish;
      end
    end
  end

  // Present one item and hold it until accepted; idle at random first.
  task automatic send_item(input epf_op_t op, input logic [4:0] a, input logic [4:0] b);
    epf_in_t it;
    it.operation = op;
    it.first_vertex = a;
    it.second_vertex = b;
    @(posedge clk);
    while (!quiet_stretch && $urandom_range(99) < 19) @(posedge clk);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    board.note_item(it);
    items_sent++;
    start <= 1'b0;
    in_item <= IN_W'($urandom);
  endtask

  task automatic add_edge(input logic [4:0] a, input logic [4:0] b);
    send_item(OP_ADD, a, b);
  endtask

  task automatic run_search();
    send_item(OP_RUN, 5'($urandom), 5'($urandom));
  endtask

  // Load a random trail over a few vertices, at random ended by an edge to base.
  task automatic random_trail();
    int unsigned len, span;
    logic [4:0] base, cur, nxt;
    len = $urandom_range(1, 10);
    span = $urandom_range(2, 8);
    base = 5'($urandom_range(0, 31 - span));
    cur = base + 5'($urandom_range(0, span - 1));
    for (int i = 0; i < len; i++) begin
      do nxt = base + 5'($urandom_range(0, span - 1)); while (nxt == cur);
      add_edge(cur, nxt);
      cur = nxt;
    end
    if ($urandom_range(1)) begin
      nxt = base;
      if (nxt != cur) add_edge(cur, nxt);
    end
  endtask

  initial begin
    board = new();
    board.clear_graph();
    start = 1'b0;
    in_item = '0;
    rst_n = 1'b0;
    idle_cycles = 0;
    items_sent = 0;
    quiet_stretch = 0;
    all_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty run, self-loop, extremes, circuit, path, odd count, split graph.
    run_search();
    add_edge(5'd7, 5'd7);
    run_search();
    add_edge(5'd0, 5'd31);
    run_search();
    add_edge(5'd31, 5'd0);
    run_search();
    run_search();
    add_edge(5'd1, 5'd2);
    add_edge(5'd3, 5'd4);
    add_edge(5'd5, 5'd6);
    run_search();
    add_edge(5'd1, 5'd2);
    add_edge(5'd2, 5'd3);
    add_edge(5'd3, 5'd1);
    add_edge(5'd10, 5'd11);
    add_edge(5'd11, 5'd10);
    run_search();
    add_edge(5'd21, 5'd10);
    add_edge(5'd10, 5'd14);
    run_search();
    // Overflow: chained edges, one more than the store holds, then a run.
    for (int i = 0; i < 33; i++) add_edge(5'(i % 31), 5'(i % 31 + 1));
    run_search();
    // Full store without overflow: a ring of 16 vertices with every edge doubled.
    for (int i = 0; i < 16; i++) begin
      add_edge(5'(i), 5'((i + 1) % 16));
      add_edge(5'((i + 1) % 16), 5'(i));
    end
    run_search();
    run_search();
    add_edge(5'd16, 5'd17);
    run_search();

    // Random: mostly well-formed trails, some noise; a stretch without idling.
    while (items_sent < 310) begin
      quiet_stretch = (items_sent > 200 && items_sent < 260);
      case ($urandom_range(9))
        0: add_edge(5'($urandom), 5'($urandom));
        1: repeat ($urandom_range(1, 5)) add_edge(5'($urandom), 5'($urandom));
        default: random_trail();
      endcase
      run_search();
      if ($urandom_range(3) == 0) run_search();
    end
    all_sent = 1;

    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d items: %0d runs found a path, %0d ended with a status.",
             items_sent, board.found_runs, board.status_runs);
    if (board.fail_count == 0 && board.pending_results.size() == 0) begin
      $display("PASS euler_path_finder");
    end else begin
      $display("FAIL euler_path_finder");
    end
    $finish;
  end
endmodule

// ----- euler_path_finder.f -----
+incdir+src
src/epf_pkg.sv
src/epf_ctrl.sv
src/epf_dp.sv
src/euler_path_finder.sv
src/epf_checker.sv
tb/testbench.sv
